// ----- rtl/bdvm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bdvm_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int MAX_SCALE    = 16;
    localparam int MAX_CHANNELS = 3;
    localparam int ROW_LIMIT    = 4096;

    localparam int SAMPLE_W = 16;
    localparam int COORD_W  = 12;
    localparam int SUM_W    = 24;
    localparam int CNT_W    = 9;
    localparam int NUM_W    = SUM_W + 1;
    localparam int DEPTH    = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int RECIP_W  = 17;

    localparam logic [2:0] CFG_SCALE   = 3'd0;
    localparam logic [2:0] CFG_SRC_W   = 3'd1;
    localparam logic [2:0] CFG_CROP_X  = 3'd2;
    localparam logic [2:0] CFG_CROP_Y  = 3'd3;
    localparam logic [2:0] CFG_OUT_W   = 3'd4;
    localparam logic [2:0] CFG_OUT_H   = 3'd5;
    localparam logic [2:0] CFG_CHAN    = 3'd6;
    localparam logic [2:0] CFG_INVALID = 3'd7;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_POS, ST_READ, ST_UPD, ST_DIV, ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul;
        logic pos;
        logic rd;
        logic upd;
        logic load;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hit;
        logic emit;
        logic div_done;
        logic out_free;
    } t_stat;

    // Rounded-up reciprocal of the scale in 16 fractional bits. For a 12-bit
    // column the product shifted down by 16 is the exact quotient.
    function automatic logic [RECIP_W-1:0] f_recip(input logic [4:0] s);
        logic [RECIP_W-1:0] r;
        case (s)
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd5:    r = 17'd13108;
            5'd6:    r = 17'd10923;
            5'd7:    r = 17'd9363;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd10:   r = 17'd6554;
            5'd11:   r = 17'd5958;
            5'd12:   r = 17'd5462;
            5'd13:   r = 17'd5042;
            5'd14:   r = 17'd4682;
            5'd15:   r = 17'd4370;
            5'd16:   r = 17'd4096;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bdvm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bdvm_div
    import bdvm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [CNT_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quo,
    output logic                  o_done
);

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_den;
    logic [CNT_W:0]   trial;
    logic             ge;

    // One quotient bit per cycle, restoring.
    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= ge ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];
        end else if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end
    end

    assign o_quo  = r_q;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ----- rtl/bdvm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bdvm_datapath
    import bdvm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_final_row,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [COORD_W-1:0]       o_out_col,
    output logic [COORD_W-1:0]       o_out_row,
    output logic [1:0]               o_chan,
    output logic [SAMPLE_W-1:0]      o_average,
    output logic                     o_has_valid
);

    // Configuration registers
    logic [4:0]          r_scale;
    logic [12:0]         r_src_w;
    logic signed [12:0]  r_crop_x;
    logic signed [12:0]  r_crop_y;
    logic [12:0]         r_out_w;
    logic [12:0]         r_out_h;
    logic [1:0]          r_chan;
    logic [SAMPLE_W-1:0] r_invalid;

    logic [4:0]  s_c;
    logic [12:0] sw_c;
    logic [1:0]  ch_c;
    logic [12:0] ow_c;
    logic [12:0] oh_c;

    always_comb begin
        s_c  = (r_scale == 5'd0) ? 5'd1 : (r_scale > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : r_scale;
        sw_c = (r_src_w == 13'd0) ? 13'd1 :
               (r_src_w > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_src_w;
        ch_c = (r_chan == 2'd0) ? 2'd1 : (r_chan > 2'(MAX_CHANNELS)) ? 2'(MAX_CHANNELS) : r_chan;
        ow_c = (r_out_w > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : r_out_w;
        oh_c = (r_out_h > 13'(ROW_LIMIT)) ? 13'(ROW_LIMIT) : r_out_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale   <= 5'd1;
            r_src_w   <= 13'(MAX_WIDTH);
            r_crop_x  <= '0;
            r_crop_y  <= '0;
            r_out_w   <= 13'(MAX_WIDTH);
            r_out_h   <= 13'(ROW_LIMIT);
            r_chan    <= 2'd1;
            r_invalid <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE:   r_scale   <= i_cfg_data[4:0];
                CFG_SRC_W:   r_src_w   <= i_cfg_data[12:0];
                CFG_CROP_X:  r_crop_x  <= $signed(i_cfg_data[12:0]);
                CFG_CROP_Y:  r_crop_y  <= $signed(i_cfg_data[12:0]);
                CFG_OUT_W:   r_out_w   <= i_cfg_data[12:0];
                CFG_OUT_H:   r_out_h   <= i_cfg_data[12:0];
                CFG_CHAN:    r_chan    <= i_cfg_data[1:0];
                CFG_INVALID: r_invalid <= i_cfg_data;
                default:     r_scale   <= r_scale;
            endcase
        end
    end

    // Source position of the next sample
    logic [COORD_W-1:0] r_col, r_row;
    logic [1:0]         r_cp;
    logic [COORD_W-1:0] ncol;
    logic [1:0]         ncp;
    logic [2:0]         cp_inc;
    logic [12:0]        col_inc;

    always_comb begin
        ncp     = (r_cp >= ch_c) ? 2'd0 : r_cp;
        ncol    = ({1'b0, r_col} >= sw_c) ? '0 : r_col;
        cp_inc  = {1'b0, ncp} + 3'd1;
        col_inc = {1'b0, ncol} + 13'd1;
    end

    logic [COORD_W-1:0]  r_x_col, r_x_row;
    logic [1:0]          r_x_cp;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cp  <= '0;
        end else if (i_cmd.accept) begin
            if (cp_inc >= {1'b0, ch_c}) begin
                r_cp <= '0;
                if (col_inc >= sw_c) begin
                    r_col <= '0;
                    r_row <= i_final_row ? '0 : r_row + 12'd1;
                end else begin
                    r_col <= col_inc[COORD_W-1:0];
                end
            end else begin
                r_col <= ncol;
                r_cp  <= cp_inc[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x_col  <= ncol;
            r_x_row  <= r_row;
            r_x_cp   <= ncp;
            r_sample <= i_sample;
            r_fin    <= i_final_row;
        end
    end

    // Block coordinates through the reciprocal of the scale
    logic [28:0]        prod_c, prod_r;
    logic [COORD_W-1:0] r_qc, r_qr;

    always_comb begin
        prod_c = 29'(r_x_col) * 29'(f_recip(s_c));
        prod_r = 29'(r_x_row) * 29'(f_recip(s_c));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_qc <= prod_c[27:16];
            r_qr <= prod_r[27:16];
        end
    end

    // Window test, block end test and line store address
    logic [16:0]        bs_c, bs_r;
    logic [COORD_W-1:0] rem_c, rem_r;
    logic signed [13:0] oc, orow;
    logic               win, col_end, row_end;
    logic [ADDR_W-1:0]  addr;

    always_comb begin
        bs_c    = 17'(r_qc) * 17'(s_c);
        bs_r    = 17'(r_qr) * 17'(s_c);
        rem_c   = r_x_col - bs_c[COORD_W-1:0];
        rem_r   = r_x_row - bs_r[COORD_W-1:0];
        oc      = $signed({2'b00, r_qc}) - $signed({r_crop_x[12], r_crop_x});
        orow    = $signed({2'b00, r_qr}) - $signed({r_crop_y[12], r_crop_y});
        win     = !oc[13] && (oc[12:0] < ow_c) && !orow[13] && (orow[12:0] < oh_c);
        col_end = (rem_c[4:0] == s_c - 5'd1) || ({1'b0, r_x_col} + 13'd1 == sw_c);
        row_end = (rem_r[4:0] == s_c - 5'd1) || r_fin;
        addr    = ADDR_W'(ADDR_W'(oc[11:0]) * ADDR_W'(ch_c)) + ADDR_W'(r_x_cp);
    end

    logic               r_hit, r_emit;
    logic [ADDR_W-1:0]  r_addr;
    logic [COORD_W-1:0] r_oc, r_orow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_emit <= 1'b0;
        end else if (i_cmd.pos) begin
            r_hit  <= win;
            r_emit <= col_end && row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos) begin
            r_addr <= addr;
            r_oc   <= oc[11:0];
            r_orow <= orow[11:0];
        end
    end

    // Line store of sum and count, swept to zero after reset
    logic [CNT_W+SUM_W-1:0] mem [DEPTH];
    logic [CNT_W+SUM_W-1:0] r_rd;
    logic [ADDR_W-1:0]      r_clr;
    logic [SUM_W-1:0]       nsum;
    logic [CNT_W-1:0]       ncnt;
    logic                   smp_ok;
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [CNT_W+SUM_W-1:0] wdata;

    always_comb begin
        smp_ok = (r_sample != r_invalid);
        nsum   = r_rd[SUM_W-1:0] + (smp_ok ? SUM_W'(r_sample) : '0);
        ncnt   = r_rd[CNT_W+SUM_W-1:SUM_W] + CNT_W'(smp_ok);
        we     = i_cmd.clr || (i_cmd.upd && r_hit);
        waddr  = i_cmd.clr ? r_clr : r_addr;
        wdata  = (i_cmd.clr || r_emit) ? '0 : {ncnt, nsum};
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + ADDR_W'(1);
        end
    end

    // Rounded mean
    logic             div_start;
    logic [NUM_W-1:0] quo;
    logic             div_done;
    logic             r_has;

    assign div_start = i_cmd.upd && r_hit && r_emit;

    bdvm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (NUM_W'(nsum) + NUM_W'(ncnt >> 1)),
        .i_den   (ncnt),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_has <= (ncnt != '0);
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out_col   <= r_oc;
            o_out_row   <= r_orow;
            o_chan      <= r_x_cp;
            o_average   <= r_has ? quo[SAMPLE_W-1:0] : '0;
            o_has_valid <= r_has;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.clr_done = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_stat.hit      = r_hit;
    assign o_stat.emit     = r_emit;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ----- rtl/bdvm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bdvm_ctrl
    import bdvm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_POS;
            end
            ST_POS: begin
                o_cmd.pos = 1'b1;
                n_state   = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = (i_stat.hit && i_stat.emit) ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/box_downscale_valid_mask.sv -----
// A sample that completes no block passes through the accept, multiply,
// position, read and update states; one that completes a block then waits
// in DIV for the divider and in EMIT until the output is free. A new sample
// is accepted only in the idle state, once the previous one is through its
// read-modify-write and any division and output load. Reset (synchronous, active
// low) is followed by a line-store clearing pass, during which no input is accepted.
`timescale 1ns / 1ps
`default_nettype none
module box_downscale_valid_mask
    import bdvm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,  // [15:0] sample
    input  wire logic        i_s_tuser,  // [0] final_row
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,  // [11:0] out_col, [23:12] out_row, [25:24] chan,
                                         // [41:26] average, [47:42] zero
    output logic             o_m_tuser   // [0] has_valid
);

    t_cmd  cmd;
    t_stat stat;

    logic [COORD_W-1:0]  out_col, out_row;
    logic [1:0]          chan;
    logic [SAMPLE_W-1:0] average;

    bdvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bdvm_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_s_tdata),
        .i_final_row (i_s_tuser),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_col   (out_col),
        .o_out_row   (out_row),
        .o_chan      (chan),
        .o_average   (average),
        .o_has_valid (o_m_tuser)
    );

    assign o_m_tdata = {6'd0, average, chan, out_row, out_col};

endmodule
`default_nettype wire
